### src/tte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the text terminal escape parser.
// No dependencies; imported by every module of the block.
package tte_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int RUN_W       = 3;

	typedef enum logic [1:0] {
		MODE_DATA = 2'd0,
		MODE_ESC  = 2'd1,
		MODE_CSI  = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		ACT_DRAW     = 4'd0,
		ACT_SCROLL   = 4'd1,
		ACT_CLEAR    = 4'd2,
		ACT_BEEP     = 4'd3,
		ACT_SLEEP    = 4'd4,
		ACT_WAKE     = 4'd5,
		ACT_LOGO     = 4'd6,
		ACT_BRIGHT   = 4'd7,
		ACT_PLAY     = 4'd8,
		ACT_QUEUE    = 4'd9,
		ACT_STANDBY  = 4'd10,
		ACT_GLYPHCOL = 4'd11
	} action_t;

	localparam logic [7:0] CH_BEL   = 8'h07;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_W     = 8'h77;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] CH_FINAL_LO = 8'h40;
	localparam logic [7:0] CH_FINAL_HI = 8'h7E;
	localparam int GLYPH_COLS = 6;

	// One queued command: act0 first, then act1 for every further item
	typedef struct packed {
		action_t          act0;
		action_t          act1;
		logic [RUN_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic pop;
		logic more;
	} back_stat_t;

endpackage
`default_nettype wire

### src/tte_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts bytes, tracks parse mode, cursor and CSI parameters,
// and turns each byte that yields actions into a queued command. Depends on tte_pkg.
module tte_front import tte_pkg::*; #(
	parameter int ESC_BUF_SIZE = 8,
	parameter int TEXT_COLS    = 14,
	parameter int TEXT_ROWS    = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	input  wire logic [7:0] byte_in,
	input  wire logic       q_full,
	output logic            byte_stall,
	output logic            push,
	output cmd_t            cmd
);

	localparam int CW  = (TEXT_COLS > 2) ? $clog2(TEXT_COLS) : 1;
	localparam int RW  = (TEXT_ROWS > 2) ? $clog2(TEXT_ROWS) : 1;
	localparam int DCW = (ESC_BUF_SIZE > 2) ? $clog2(ESC_BUF_SIZE) : 1;

	mode_t           mode_q, mode_d;
	logic [RW-1:0]   row_q, row_d;
	logic [CW-1:0]   col_q, col_d;
	logic [15:0]     acc_q, acc_d;
	logic [DCW-1:0]  dcnt_q, dcnt_d;
	logic            stop_q, stop_d;
	logic [1:0]      pcnt_q, pcnt_d;
	logic [15:0]     slot0_q, slot0_d;
	logic [15:0]     slot1_q, slot1_d;
	logic [15:0]     p0, p1;
	logic            accept;
	logic            is_param, is_final, last_row;

	assign byte_stall = q_full;
	assign accept     = byte_valid && !q_full;
	assign is_param   = (byte_in[7:4] == 4'h3);
	assign is_final   = (byte_in >= CH_FINAL_LO) && (byte_in <= CH_FINAL_HI);
	assign last_row   = (row_q == RW'(TEXT_ROWS - 1));
	// parameter values as they stand after the current one is closed
	assign p0 = (pcnt_q == 2'd0) ? acc_q : slot0_q;
	assign p1 = (pcnt_q == 2'd1) ? acc_q : slot1_q;
	assign push = accept && (cmd.cnt != '0);

	always_comb begin
		mode_d = mode_q;
		unique case (mode_q)
			MODE_DATA: begin
				if (byte_in == CH_ESC) mode_d = MODE_ESC;
			end
			MODE_ESC: begin
				mode_d = (byte_in == CH_LBRK) ? MODE_CSI : MODE_DATA;
			end
			MODE_CSI: begin
				if (!is_param && is_final) mode_d = MODE_DATA;
			end
			default: mode_d = MODE_DATA;
		endcase
	end

	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		acc_d   = acc_q;
		dcnt_d  = dcnt_q;
		stop_d  = stop_q;
		pcnt_d  = pcnt_q;
		slot0_d = slot0_q;
		slot1_d = slot1_q;
		cmd.act0 = ACT_DRAW;
		cmd.act1 = ACT_SCROLL;
		cmd.cnt  = '0;
		unique case (mode_q)
			MODE_DATA: begin
				if (byte_in == CH_BEL) begin
					cmd.act0 = ACT_BEEP;
					cmd.cnt  = RUN_W'(1);
				end else if (byte_in == CH_BS) begin
					if (row_q != '0 || col_q != '0) begin
						if (col_q != '0) col_d = col_q - 1'b1;
						else row_d = row_q - 1'b1;
						cmd.cnt = RUN_W'(1);
					end
				end else if (byte_in == CH_LF) begin
					col_d = '0;
					if (last_row) begin
						cmd.act0 = ACT_SCROLL;
						cmd.cnt  = RUN_W'(1);
					end else begin
						row_d = row_q + 1'b1;
					end
				end else if (byte_in == CH_FF) begin
					cmd.act0 = ACT_CLEAR;
					cmd.cnt  = RUN_W'(1);
					row_d    = '0;
					col_d    = '0;
				end else if (byte_in == CH_CR) begin
					col_d = '0;
				end else if (byte_in >= CH_SPACE) begin
					cmd.cnt = RUN_W'(1);
					if (col_q == CW'(TEXT_COLS - 1)) begin
						col_d = '0;
						if (last_row) cmd.cnt = RUN_W'(2);
						else row_d = row_q + 1'b1;
					end else begin
						col_d = col_q + 1'b1;
					end
				end
			end
			MODE_ESC: begin
				if (byte_in == CH_LBRK) begin
					acc_d   = '0;
					dcnt_d  = '0;
					stop_d  = 1'b0;
					pcnt_d  = '0;
					slot0_d = '0;
					slot1_d = '0;
				end else if (byte_in == CH_S) begin
					cmd.act0 = ACT_SLEEP;
					cmd.cnt  = RUN_W'(1);
				end else if (byte_in == CH_W) begin
					cmd.act0 = ACT_WAKE;
					cmd.cnt  = RUN_W'(1);
				end else if (byte_in == CH_L) begin
					cmd.act0 = ACT_LOGO;
					cmd.cnt  = RUN_W'(1);
				end
			end
			MODE_CSI: begin
				if (is_param) begin
					if (dcnt_q < DCW'(ESC_BUF_SIZE - 1)) begin
						dcnt_d = dcnt_q + 1'b1;
						if (!stop_q && byte_in <= CH_NINE)
							acc_d = (acc_q << 3) + (acc_q << 1) + {12'd0, byte_in[3:0]};
						else
							stop_d = 1'b1;
					end
				end else begin
					if (pcnt_q == 2'd0) begin
						slot0_d = acc_q;
						pcnt_d  = 2'd1;
					end else if (pcnt_q == 2'd1) begin
						slot1_d = acc_q;
						pcnt_d  = 2'd2;
					end
					acc_d  = '0;
					dcnt_d = '0;
					stop_d = 1'b0;
					if (is_final) begin
						if (byte_in == CH_B) begin
							cmd.act0 = ACT_BRIGHT;
							cmd.cnt  = RUN_W'(1);
						end else if (byte_in == CH_P) begin
							cmd.act0 = ACT_PLAY;
							cmd.cnt  = RUN_W'(1);
						end else if (byte_in == CH_Q) begin
							cmd.act0 = ACT_QUEUE;
							cmd.cnt  = RUN_W'(1);
						end else if (byte_in == CH_S) begin
							cmd.act0 = ACT_STANDBY;
							cmd.cnt  = RUN_W'(1);
						end else if (byte_in == CH_C) begin
							if (p0[7]) begin
								cmd.act0 = ACT_GLYPHCOL;
								cmd.act1 = ACT_GLYPHCOL;
								cmd.cnt  = RUN_W'(GLYPH_COLS);
							end
						end else if (byte_in == CH_Z) begin
							col_d = (p0 >= 16'(TEXT_COLS)) ? CW'(TEXT_COLS - 1) : p0[CW-1:0];
							row_d = (p1 >= 16'(TEXT_ROWS)) ? RW'(TEXT_ROWS - 1) : p1[RW-1:0];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DATA;
			row_q   <= '0;
			col_q   <= '0;
			acc_q   <= '0;
			dcnt_q  <= '0;
			stop_q  <= 1'b0;
			pcnt_q  <= '0;
			slot0_q <= '0;
			slot1_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			row_q   <= row_d;
			col_q   <= col_d;
			acc_q   <= acc_d;
			dcnt_q  <= dcnt_d;
			stop_q  <= stop_d;
			pcnt_q  <= pcnt_d;
			slot0_q <= slot0_d;
			slot1_q <= slot1_d;
		end
	end

endmodule
`default_nettype wire

### src/tte_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short command queue between front end and back end.
// Depends on tte_pkg.
module tte_queue import tte_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire cmd_t        wr_cmd,
	input  wire logic        pop,
	output cmd_t             rd_cmd,
	output logic             full,
	output logic             empty,
	output logic [QCNT_W-1:0] count
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (cnt_q == '0);
	assign count  = cnt_q;
	assign rd_cmd = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

### src/tte_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: expands queued commands into single action items through
// an output register. Depends on tte_pkg.
module tte_back import tte_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic q_empty,
	input  wire logic action_stall,
	output logic      action_valid,
	output logic [3:0] action,
	output back_stat_t stat
);

	logic             vld_q;
	action_t          act_q;
	action_t          act1_q;
	logic [RUN_W-1:0] rem_q;
	logic             adv;

	assign adv          = !vld_q || !action_stall;
	assign stat.more    = (rem_q != '0);
	assign stat.pop     = adv && !stat.more && !q_empty;
	assign action_valid = vld_q;
	assign action       = act_q;

	always_ff @(posedge clk) begin
		if (stat.pop) begin
			act_q  <= head.act0;
			act1_q <= head.act1;
		end else if (adv && stat.more) begin
			act_q <= act1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			rem_q <= '0;
		end else if (adv) begin
			if (stat.more) begin
				vld_q <= 1'b1;
				rem_q <= rem_q - 1'b1;
			end else if (!q_empty) begin
				vld_q <= 1'b1;
				rem_q <= head.cnt - 1'b1;
			end else begin
				vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

### src/text_terminal_escape_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// Text terminal escape parser: one byte in per cycle, display actions out.
// Instantiates tte_front, tte_queue and tte_back; depends on tte_pkg.
//
// Takes one byte per clock when byte_stall is low and emits one action per
// clock when action_stall is low. Each byte updates parse state and cursor
// in the cycle it is taken; its actions (none, one, two for draw plus
// scroll, six for a glyph definition) go through a four-entry command queue
// and appear one per cycle, while action_stall is low, from the output
// register. byte_stall rises only when the queue is full, so sustained input
// runs at one byte per cycle unless a downstream stall or a run of bytes with
// more than one action (line wraps that scroll, glyph definitions) holds the
// output back.
module text_terminal_escape_parser import tte_pkg::*; #(
	parameter int ESC_BUF_SIZE = 8,
	parameter int TEXT_COLS    = 14,
	parameter int TEXT_ROWS    = 6
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] byte_in,
	output logic            action_valid,
	input  wire logic       action_stall,
	output logic [3:0]      action
);

	cmd_t              wr_cmd, head;
	logic              push, q_full, q_empty;
	logic [QCNT_W-1:0] q_count;
	back_stat_t        bk_stat;

	tte_front #(
		.ESC_BUF_SIZE(ESC_BUF_SIZE),
		.TEXT_COLS   (TEXT_COLS),
		.TEXT_ROWS   (TEXT_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_in   (byte_in),
		.q_full    (q_full),
		.byte_stall(byte_stall),
		.push      (push),
		.cmd       (wr_cmd)
	);

	tte_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (bk_stat.pop),
		.rd_cmd(head),
		.full  (q_full),
		.empty (q_empty),
		.count (q_count)
	);

	tte_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.action_stall(action_stall),
		.action_valid(action_valid),
		.action      (action),
		.stat        (bk_stat)
	);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("command queue count out of range");

	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		action_valid |-> (action <= 4'(ACT_GLYPHCOL)))
		else $error("undefined action code");

	a_drain_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(action_valid && !action_stall && !bk_stat.more && q_empty) |=> !action_valid)
		else $error("action item without a queued command");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.pop |-> (!q_empty && !bk_stat.more))
		else $error("queue popped while empty or during a run");

endmodule
`default_nettype wire

### tb/sv/tb_text_terminal_escape_parser.sv
`timescale 1ns / 1ps
// Testbench for text_terminal_escape_parser: drives bytes and checks each display action
// in order against a built-in parser/cursor predictor, with random idling on both sides.
// Depends on tte_pkg and the text_terminal_escape_parser RTL.
module tb_text_terminal_escape_parser;
	import tte_pkg::*;

	localparam int ESC_BUF_SIZE  = 8;
	localparam int PARAM_SLOTS   = 8;
	localparam int TEXT_COLS     = 14;
	localparam int TEXT_ROWS     = 6;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 60;

	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_PARAM_HI = 8'h3F;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_HIGH_SEP = 8'h7F;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       byte_valid = 1'b0;
	logic       byte_stall;
	logic [7:0] byte_in = 8'h00;
	logic       action_valid;
	logic       action_stall = 1'b0;
	logic [3:0] action;

	action_t expected_actions [$];
	int      error_count = 0;
	int      bytes_sent = 0;
	bit      idle_on = 1'b1;
	int      hold_cycles = 0;
	int      stall_left = 0;

	// predictor state
	mode_t       term_mode;
	logic [2:0]  cur_row;
	logic [3:0]  cur_col;
	logic [15:0] num_acc;
	logic [2:0]  num_len;
	bit          num_stopped;
	int          arg_count;
	logic [15:0] arg_val [PARAM_SLOTS];

	text_terminal_escape_parser #(
		.ESC_BUF_SIZE(ESC_BUF_SIZE),
		.TEXT_COLS(TEXT_COLS),
		.TEXT_ROWS(TEXT_ROWS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_in(byte_in),
		.action_valid(action_valid),
		.action_stall(action_stall),
		.action(action)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_text_terminal_escape_parser NOT OK");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 25);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	// --- predictor ---
	function automatic void clear_number();
		num_acc = '0;
		num_len = '0;
		num_stopped = 1'b0;
	endfunction

	function automatic void reset_terminal();
		term_mode = MODE_DATA;
		cur_row = '0;
		cur_col = '0;
		clear_number();
		arg_count = 0;
		foreach (arg_val[i])
			arg_val[i] = '0;
	endfunction

	function automatic void line_feed();
		cur_col = '0;
		if (cur_row >= TEXT_ROWS - 1)
			expected_actions.push_back(ACT_SCROLL);
		else
			cur_row++;
	endfunction

	function automatic void predict_actions(input logic [7:0] b);
		case (term_mode)
		MODE_DATA: begin
			if (b == CH_BEL) begin
				expected_actions.push_back(ACT_BEEP);
			end else if (b == CH_BS) begin
				if (cur_row != 0 || cur_col != 0) begin
					if (cur_col != 0)
						cur_col--;
					else
						cur_row--;
					expected_actions.push_back(ACT_DRAW);
				end
			end else if (b == CH_LF) begin
				line_feed();
			end else if (b == CH_FF) begin
				expected_actions.push_back(ACT_CLEAR);
				cur_row = '0;
				cur_col = '0;
			end else if (b == CH_CR) begin
				cur_col = '0;
			end else if (b == CH_ESC) begin
				term_mode = MODE_ESC;
			end else if (b >= CH_SPACE) begin
				expected_actions.push_back(ACT_DRAW);
				cur_col++;
				if (cur_col >= TEXT_COLS)
					line_feed();
			end
		end
		MODE_ESC: begin
			term_mode = MODE_DATA;
			if (b == CH_LBRK) begin
				clear_number();
				arg_count = 0;
				foreach (arg_val[i])
					arg_val[i] = '0;
				term_mode = MODE_CSI;
			end else if (b == CH_S) begin
				expected_actions.push_back(ACT_SLEEP);
			end else if (b == CH_W) begin
				expected_actions.push_back(ACT_WAKE);
			end else if (b == CH_L) begin
				expected_actions.push_back(ACT_LOGO);
			end
		end
		MODE_CSI: begin
			if (b >= CH_ZERO && b <= CH_PARAM_HI) begin
				if (num_len < ESC_BUF_SIZE - 1) begin
					num_len++;
					if (!num_stopped && b <= CH_NINE)
						num_acc = 16'(num_acc * 10 + (b - CH_ZERO));
					else
						num_stopped = 1'b1;
				end
			end else begin
				if (arg_count < PARAM_SLOTS) begin
					arg_val[arg_count] = num_acc;
					arg_count++;
				end
				clear_number();
				if (b >= CH_FINAL_LO && b <= CH_FINAL_HI) begin
					if (b == CH_B) begin
						expected_actions.push_back(ACT_BRIGHT);
					end else if (b == CH_P) begin
						expected_actions.push_back(ACT_PLAY);
					end else if (b == CH_Q) begin
						expected_actions.push_back(ACT_QUEUE);
					end else if (b == CH_S) begin
						expected_actions.push_back(ACT_STANDBY);
					end else if (b == CH_C) begin
						if (arg_val[0][7:0] >= 8'h80)
							repeat (GLYPH_COLS) expected_actions.push_back(ACT_GLYPHCOL);
					end else if (b == CH_Z) begin
						cur_col = (arg_val[0] >= TEXT_COLS) ? 4'(TEXT_COLS - 1) : arg_val[0][3:0];
						cur_row = (arg_val[1] >= TEXT_ROWS) ? 3'(TEXT_ROWS - 1) : arg_val[1][2:0];
					end
					term_mode = MODE_DATA;
				end
			end
		end
		default: term_mode = MODE_DATA;
		endcase
	endfunction

	// --- driving ---
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			byte_in <= 8'($urandom);
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		predict_actions(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_escape(input string body);
		send_byte(CH_ESC);
		send_text(body);
	endtask

	task automatic wait_results();
		byte_valid <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver side: random stalls, plus a long hold when a test asks for one
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			action_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			action_stall <= 1'b1;
		end else begin
			stall_left = pick_gap();
			if (stall_left > 0) begin
				stall_left--;
				action_stall <= 1'b1;
			end else begin
				action_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_actions
		action_t want;
		if (arst_n && action_valid && !action_stall) begin
			if (expected_actions.size() == 0) begin
				report_mismatch($sformatf("unexpected action %0d", action));
			end else begin
				want = expected_actions.pop_front();
				if (action !== 4'(want))
					report_mismatch($sformatf("action %0d, expected %0d (%s)",
						action, want, want.name()));
			end
		end
	end

	// --- random stimulus ---
	function automatic logic [7:0] random_separator();
		case ($urandom_range(0, 2))
		0: return CH_COMMA;
		1: return 8'($urandom_range(0, CH_ZERO - 1));
		default: return 8'($urandom_range(CH_HIGH_SEP, 255));
		endcase
	endfunction

	function automatic logic [7:0] random_final();
		case ($urandom_range(0, 7))
		0: return CH_B;
		1: return CH_P;
		2: return CH_Q;
		3: return CH_S;
		4, 5: return CH_C;
		6: return CH_Z;
		default: return 8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI));
		endcase
	endfunction

	task automatic send_random_csi();
		int nparams;
		int v;
		send_byte(CH_ESC);
		send_byte(CH_LBRK);
		nparams = $urandom_range(0, 3);
		for (int i = 0; i < nparams; i++) begin
			if (i > 0)
				send_byte(random_separator());
			case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 20);
			1: v = $urandom_range(128, 255) + 256 * $urandom_range(0, 255);
			2: v = $urandom_range(0, 9999999);
			default: v = $urandom_range(0, 300);
			endcase
			send_text($sformatf("%0d", v));
			if ($urandom_range(0, 5) == 0) begin
				send_byte(8'($urandom_range(CH_NINE + 1, CH_PARAM_HI)));
				send_text($sformatf("%0d", $urandom_range(0, 99)));
			end
		end
		send_byte(random_final());
	endtask

	task automatic send_random_chunk();
		int n;
		n = $urandom_range(1, 8);
		case ($urandom_range(0, 9))
		0, 1: begin
			repeat (n) send_byte(8'($urandom_range(CH_SPACE, 255)));
		end
		2: begin
			case ($urandom_range(0, 5))
			0: send_byte(CH_BEL);
			1: send_byte(CH_BS);
			2: send_byte(CH_LF);
			3: send_byte(CH_FF);
			4: send_byte(CH_CR);
			default: send_byte(8'($urandom_range(0, CH_SPACE - 1)));
			endcase
		end
		3: begin
			send_byte(CH_ESC);
			case ($urandom_range(0, 4))
			0: send_byte(CH_S);
			1: send_byte(CH_W);
			2: send_byte(CH_L);
			3: send_byte(CH_LBRK);
			default: send_byte(8'($urandom));
			endcase
		end
		8: begin
			send_byte(CH_ESC);
			send_byte(CH_LBRK);
			repeat (n) send_byte(8'($urandom));
		end
		9: begin
			repeat (n) send_byte(8'($urandom));
		end
		default: send_random_csi();
		endcase
	endtask

	// --- tests ---
	task automatic test_control_bytes();
		send_byte(CH_BS);
		send_byte(CH_BEL);
		send_byte(8'h00);
		send_byte(8'h1F);
		send_byte(CH_SPACE);
		send_byte(8'hFF);
		send_byte(CH_HIGH_SEP);
		send_byte(CH_BS);
		send_byte(CH_CR);
		send_byte(CH_LF);
		send_byte(CH_FF);
	endtask

	task automatic test_wrap_and_scroll();
		send_escape("[13,5z");
		send_text("A");
		send_byte(CH_BS);
		send_escape("[99,99z");
		send_byte(CH_LF);
		send_escape("[0,1z");
		send_byte(CH_BS);
		send_byte(CH_BS);
	endtask

	task automatic test_short_escapes();
		send_escape("s");
		send_escape("w");
		send_escape("l");
		send_escape("x");
		send_byte(CH_ESC);
		send_byte(CH_ESC);
	endtask

	task automatic test_csi_commands();
		send_escape("[b");
		send_escape("[1;2p");
		send_escape("[q");
		send_escape("[s");
		send_escape("[7A");
		send_escape("[5");
		send_byte(8'h80);
		send_byte(8'hFF);
		send_text(" 3~");
	endtask

	task automatic test_glyph_and_overflow();
		send_escape("[200c");
		send_escape("[127c");
		send_escape("[128;5c");
		send_escape("[9999999c");
		send_escape("[99999999c");
		send_escape("[65664c");
		send_escape("[1:9c");
		send_escape("[1,2,3,4,5,6,7,8,9,10z");
		send_text("Q");
	endtask

	task automatic test_output_hold();
		idle_on = 1'b0;
		hold_cycles = 80;
		repeat (3) send_escape("[255c");
		send_text("hold on");
		idle_on = 1'b1;
		wait_results();
	endtask

	task automatic test_burst();
		idle_on = 1'b0;
		send_byte(CH_FF);
		repeat (60) send_byte(8'($urandom_range(CH_SPACE, 255)));
		send_escape("[130c");
		idle_on = 1'b1;
		wait_results();
	endtask

	task automatic test_random_stream();
		int first;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_ITEMS)
			send_random_chunk();
		wait_results();
	endtask

	initial begin
		reset_terminal();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_control_bytes();
		test_wrap_and_scroll();
		test_short_escapes();
		test_csi_commands();
		test_glyph_and_overflow();
		wait_results();
		test_output_hold();
		test_burst();
		test_random_stream();
		if (error_count == 0 && expected_actions.size() == 0)
			$display("tb_text_terminal_escape_parser OK");
		else
			$display("tb_text_terminal_escape_parser NOT OK");
		$finish;
	end

endmodule
